// ----- sv/etcal_pkg.sv -----
package etcal_pkg;

    localparam int EPOCH_W  = 32;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 6;
    localparam int HOUR_W   = 5;
    localparam int WDAY_W   = 3;
    localparam int YEAR_W   = 8;
    localparam int MONTH_W  = 4;
    localparam int MDAY_W   = 5;
    localparam int DAYS_W   = 16;   // days since 1970 stays below 49711
    localparam int REM_W    = 6;    // remainder of a division by at most 60
    localparam int PC_W     = 4;
    localparam int YLEN_W   = 9;
    localparam int PROD_W   = 2 * EPOCH_W;
    localparam int SH_W     = 6;

    // micro-operations
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_DIV     = 4'd2;
    localparam logic [3:0] OP_SEC     = 4'd3;
    localparam logic [3:0] OP_MIN     = 4'd4;
    localparam logic [3:0] OP_HOUR    = 4'd5;
    localparam logic [3:0] OP_WDAY    = 4'd6;
    localparam logic [3:0] OP_YEAR    = 4'd7;
    localparam logic [3:0] OP_MONTH   = 4'd8;
    localparam logic [3:0] OP_EMIT    = 4'd9;

    // jump conditions: when true the sequencer takes the jump target
    localparam logic [2:0] C_NEVER     = 3'd0;
    localparam logic [2:0] C_NO_BEAT   = 3'd1;
    localparam logic [2:0] C_YEAR_FIT  = 3'd3;
    localparam logic [2:0] C_MONTH_FIT = 3'd4;
    localparam logic [2:0] C_OUT_BUSY  = 3'd5;

    // divisor selects
    localparam logic [1:0] D_60 = 2'd0;
    localparam logic [1:0] D_24 = 2'd1;
    localparam logic [1:0] D_7  = 2'd2;

    localparam logic [REM_W-1:0] SECS_IN_MIN  = 6'd60;
    localparam logic [REM_W-1:0] HOURS_IN_DAY = 6'd24;
    localparam logic [REM_W-1:0] DAYS_IN_WEEK = 6'd7;

    // reciprocals rounded up: the quotient is the product shifted right by the paired amount
    localparam logic [EPOCH_W-1:0] RCP_60 = 32'h8888_8889;
    localparam logic [EPOCH_W-1:0] RCP_24 = 32'hAAAA_AAAB;
    localparam logic [EPOCH_W-1:0] RCP_7  = 32'h9249_2493;
    localparam logic [SH_W-1:0]    SH_60  = 6'd37;
    localparam logic [SH_W-1:0]    SH_24  = 6'd36;
    localparam logic [SH_W-1:0]    SH_7   = 6'd34;

    // program addresses
    localparam logic [PC_W-1:0] A_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] A_DIVS  = 4'd1;
    localparam logic [PC_W-1:0] A_SEC   = 4'd2;
    localparam logic [PC_W-1:0] A_DIVM  = 4'd3;
    localparam logic [PC_W-1:0] A_MIN   = 4'd4;
    localparam logic [PC_W-1:0] A_DIVH  = 4'd5;
    localparam logic [PC_W-1:0] A_HOUR  = 4'd6;
    localparam logic [PC_W-1:0] A_DIVW  = 4'd7;
    localparam logic [PC_W-1:0] A_WDAY  = 4'd8;
    localparam logic [PC_W-1:0] A_YEAR  = 4'd9;
    localparam logic [PC_W-1:0] A_MONTH = 4'd10;
    localparam logic [PC_W-1:0] A_EMIT  = 4'd11;

    // year offsets of the century years inside the 8-bit range
    localparam logic [YEAR_W-1:0] OFF_2100 = 8'd130;
    localparam logic [YEAR_W-1:0] OFF_2200 = 8'd230;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [1:0]      dsel;
        logic [PC_W-1:0] jmp;
        logic [PC_W-1:0] nxt;
    } uword_t;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] dsel;
    } ctrl_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
        logic out_busy;
    } stat_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, cond: C_NEVER, dsel: D_60, jmp: A_WAIT, nxt: A_WAIT};
        unique case (addr)
            A_WAIT:  w = '{op: OP_LOAD,  cond: C_NO_BEAT,   dsel: D_60, jmp: A_WAIT,  nxt: A_DIVS};
            A_DIVS:  w = '{op: OP_DIV,   cond: C_NEVER,     dsel: D_60, jmp: A_SEC,   nxt: A_SEC};
            A_SEC:   w = '{op: OP_SEC,   cond: C_NEVER,     dsel: D_60, jmp: A_DIVM,  nxt: A_DIVM};
            A_DIVM:  w = '{op: OP_DIV,   cond: C_NEVER,     dsel: D_60, jmp: A_MIN,   nxt: A_MIN};
            A_MIN:   w = '{op: OP_MIN,   cond: C_NEVER,     dsel: D_60, jmp: A_DIVH,  nxt: A_DIVH};
            A_DIVH:  w = '{op: OP_DIV,   cond: C_NEVER,     dsel: D_24, jmp: A_HOUR,  nxt: A_HOUR};
            A_HOUR:  w = '{op: OP_HOUR,  cond: C_NEVER,     dsel: D_24, jmp: A_DIVW,  nxt: A_DIVW};
            A_DIVW:  w = '{op: OP_DIV,   cond: C_NEVER,     dsel: D_7,  jmp: A_WDAY,  nxt: A_WDAY};
            A_WDAY:  w = '{op: OP_WDAY,  cond: C_NEVER,     dsel: D_7,  jmp: A_YEAR,  nxt: A_YEAR};
            A_YEAR:  w = '{op: OP_YEAR,  cond: C_YEAR_FIT,  dsel: D_7,  jmp: A_YEAR,  nxt: A_MONTH};
            A_MONTH: w = '{op: OP_MONTH, cond: C_MONTH_FIT, dsel: D_7,  jmp: A_MONTH, nxt: A_EMIT};
            A_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  dsel: D_7,  jmp: A_EMIT,  nxt: A_WAIT};
            default: w = '{op: OP_NOP,   cond: C_NEVER,     dsel: D_60, jmp: A_WAIT,  nxt: A_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [REM_W-1:0] divisor(input logic [1:0] dsel);
        logic [REM_W-1:0] d;
        unique case (dsel)
            D_60:    d = SECS_IN_MIN;
            D_24:    d = HOURS_IN_DAY;
            D_7:     d = DAYS_IN_WEEK;
            default: d = SECS_IN_MIN;
        endcase
        return d;
    endfunction

    function automatic logic [EPOCH_W-1:0] recip(input logic [1:0] dsel);
        logic [EPOCH_W-1:0] m;
        unique case (dsel)
            D_60:    m = RCP_60;
            D_24:    m = RCP_24;
            D_7:     m = RCP_7;
            default: m = RCP_60;
        endcase
        return m;
    endfunction

    function automatic logic [SH_W-1:0] rshift(input logic [1:0] dsel);
        logic [SH_W-1:0] s;
        unique case (dsel)
            D_60:    s = SH_60;
            D_24:    s = SH_24;
            D_7:     s = SH_7;
            default: s = SH_60;
        endcase
        return s;
    endfunction

    // 1970 + off is divisible by 4 when off is 2 mod 4; 2100 and 2200 are not leap
    function automatic logic is_leap(input logic [YEAR_W-1:0] off);
        return (off[1:0] == 2'd2) && (off != OFF_2100) && (off != OFF_2200);
    endfunction

    function automatic logic [YLEN_W-1:0] year_len(input logic [YEAR_W-1:0] off);
        return is_leap(off) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
                                                    input logic leap);
        logic [MDAY_W-1:0] len;
        unique case (mon)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:
                     len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- sv/etcal_useq.sv -----
module etcal_useq
    import etcal_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  in_ready
);

    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          word;
    logic            take;

    assign word = ucode(pc_reg);

    always_comb begin
        unique case (word.cond)
            C_NEVER:     take = 1'b0;
            C_NO_BEAT:   take = !in_valid;
            C_YEAR_FIT:  take = stat.year_fit;
            C_MONTH_FIT: take = stat.month_fit;
            C_OUT_BUSY:  take = stat.out_busy;
            default:     take = 1'b0;
        endcase
        pc_next = take ? word.jmp : word.nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= A_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.dsel = word.dsel;
    assign in_ready  = (word.op == OP_LOAD);

endmodule

// ----- sv/etcal_datapath.sv -----
module etcal_datapath
    import etcal_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_t                ctrl,
    input  logic                 in_valid,
    input  logic [EPOCH_W-1:0]   in_epoch,
    output stat_t                stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SEC_W-1:0]     m_second,
    output logic [MIN_W-1:0]     m_minute,
    output logic [HOUR_W-1:0]    m_hour,
    output logic [WDAY_W-1:0]    m_weekday,
    output logic [YEAR_W-1:0]    m_year_offset,
    output logic [MONTH_W-1:0]   m_month,
    output logic [MDAY_W-1:0]    m_day_of_month
);

    logic [EPOCH_W-1:0] q_reg, q_next;
    logic [EPOCH_W-1:0] quo_reg, quo_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] mon_reg, mon_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [WDAY_W-1:0]  wday_reg, wday_next;
    logic               m_valid_reg, m_valid_next;
    logic [SEC_W-1:0]   o_sec_reg, o_sec_next;
    logic [MIN_W-1:0]   o_min_reg, o_min_next;
    logic [HOUR_W-1:0]  o_hour_reg, o_hour_next;
    logic [WDAY_W-1:0]  o_wday_reg, o_wday_next;
    logic [YEAR_W-1:0]  o_year_reg, o_year_next;
    logic [MONTH_W-1:0] o_mon_reg, o_mon_next;
    logic [MDAY_W-1:0]  o_mday_reg, o_mday_next;

    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_sh;
    logic [REM_W-1:0]   dval;
    logic [REM_W-1:0]   rem;
    logic [YLEN_W-1:0]  ylen;
    logic [MDAY_W-1:0]  mlen;
    logic               out_busy;

    // quotient by reciprocal multiplication; the remainder is below 64, so its low bits do
    assign dval    = divisor(ctrl.dsel);
    assign prod    = PROD_W'(q_reg) * PROD_W'(recip(ctrl.dsel));
    assign prod_sh = prod >> rshift(ctrl.dsel);
    assign rem     = q_reg[REM_W-1:0] - REM_W'(quo_reg[REM_W-1:0] * dval);

    assign ylen = year_len(year_reg);
    assign mlen = month_len(mon_reg, is_leap(year_reg));

    assign out_busy       = m_valid_reg && !m_ready;
    assign stat.year_fit  = (days_reg >= DAYS_W'(ylen));
    assign stat.month_fit = (days_reg >= DAYS_W'(mlen)) && (mon_reg < MON_DEC);
    assign stat.out_busy  = out_busy;

    always_comb begin
        q_next       = q_reg;
        quo_next     = quo_reg;
        days_next    = days_reg;
        year_next    = year_reg;
        mon_next     = mon_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        wday_next    = wday_reg;
        o_sec_next   = o_sec_reg;
        o_min_next   = o_min_reg;
        o_hour_next  = o_hour_reg;
        o_wday_next  = o_wday_reg;
        o_year_next  = o_year_reg;
        o_mon_next   = o_mon_reg;
        o_mday_next  = o_mday_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (ctrl.op)
            OP_LOAD: begin
                if (in_valid) begin
                    q_next = in_epoch;
                end
            end
            OP_DIV: begin
                quo_next = prod_sh[EPOCH_W-1:0];
            end
            OP_SEC: begin
                sec_next = rem;
                q_next   = quo_reg;
            end
            OP_MIN: begin
                min_next = rem;
                q_next   = quo_reg;
            end
            OP_HOUR: begin
                // 1 january 1970 was a thursday: weekday from days + 4
                hour_next = rem[HOUR_W-1:0];
                days_next = quo_reg[DAYS_W-1:0];
                q_next    = EPOCH_W'(quo_reg[DAYS_W-1:0]) + EPOCH_W'(4);
            end
            OP_WDAY: begin
                wday_next = WDAY_W'(rem[WDAY_W-1:0] + 1'b1);
                year_next = '0;
                mon_next  = '0;
            end
            OP_YEAR: begin
                if (stat.year_fit) begin
                    days_next = days_reg - DAYS_W'(ylen);
                    year_next = year_reg + 1'b1;
                end
            end
            OP_MONTH: begin
                if (stat.month_fit) begin
                    days_next = days_reg - DAYS_W'(mlen);
                    mon_next  = mon_reg + 1'b1;
                end
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    o_sec_next   = sec_reg;
                    o_min_next   = min_reg;
                    o_hour_next  = hour_reg;
                    o_wday_next  = wday_reg;
                    o_year_next  = year_reg;
                    o_mon_next   = mon_reg + 1'b1;
                    o_mday_next  = MDAY_W'(days_reg[MDAY_W-1:0] + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg      <= q_next;
        quo_reg    <= quo_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        mon_reg    <= mon_next;
        sec_reg    <= sec_next;
        min_reg    <= min_next;
        hour_reg   <= hour_next;
        wday_reg   <= wday_next;
        o_sec_reg  <= o_sec_next;
        o_min_reg  <= o_min_next;
        o_hour_reg <= o_hour_next;
        o_wday_reg <= o_wday_next;
        o_year_reg <= o_year_next;
        o_mon_reg  <= o_mon_next;
        o_mday_reg <= o_mday_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_second       = o_sec_reg;
    assign m_minute       = o_min_reg;
    assign m_hour         = o_hour_reg;
    assign m_weekday      = o_wday_reg;
    assign m_year_offset  = o_year_reg;
    assign m_month        = o_mon_reg;
    assign m_day_of_month = o_mday_reg;

endmodule

// ----- sv/epoch_seconds_to_calendar_top.sv -----
// Epoch seconds to calendar breakdown (Gregorian, UTC).
// Input channel s_*: one beat carries s_epoch_seconds, unsigned seconds since
// 1970-01-01 00:00:00. Result channel m_*: one beat per input with second,
// minute, hour, weekday (1 is Sunday), year_offset (year - 1970), month (1..12)
// and day_of_month (1..31).
// A small microprogram drives a shared reciprocal multiplier: each of /60, /60,
// /24 and the weekday mod 7 takes a quotient step, then a remainder step; then
// one year a cycle and one month a cycle are stripped.
// s_ready returns once the result is loaded into the output register, so the
// block takes no new input beat until it is through with the current one.
// s_ready is high only while the sequencer waits for an input beat.
// A result waits in the output register while m_ready is low; the next item is
// taken and worked on meanwhile and holds at its last step until the register
// frees.
// Reset (aresetn low, synchronous) returns the sequencer to the wait step and
// drops m_valid; no clearing pass is needed.
module epoch_seconds_to_calendar_top
    import etcal_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [EPOCH_W-1:0]   s_epoch_seconds,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SEC_W-1:0]     m_second,
    output logic [MIN_W-1:0]     m_minute,
    output logic [HOUR_W-1:0]    m_hour,
    output logic [WDAY_W-1:0]    m_weekday,
    output logic [YEAR_W-1:0]    m_year_offset,
    output logic [MONTH_W-1:0]   m_month,
    output logic [MDAY_W-1:0]    m_day_of_month
);

    ctrl_t ctrl;
    stat_t stat;

    etcal_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (s_ready)
    );

    etcal_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .in_valid       (s_valid),
        .in_epoch       (s_epoch_seconds),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_second       (m_second),
        .m_minute       (m_minute),
        .m_hour         (m_hour),
        .m_weekday      (m_weekday),
        .m_year_offset  (m_year_offset),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month)
    );

endmodule

// ----- verif/cal_breakdown_checker.sv -----
`timescale 1ns / 100ps

module cal_breakdown_checker
    import etcal_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [EPOCH_W-1:0]   s_epoch_seconds,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [SEC_W-1:0]     m_second,
    input  logic [MIN_W-1:0]     m_minute,
    input  logic [HOUR_W-1:0]    m_hour,
    input  logic [WDAY_W-1:0]    m_weekday,
    input  logic [YEAR_W-1:0]    m_year_offset,
    input  logic [MONTH_W-1:0]   m_month,
    input  logic [MDAY_W-1:0]    m_day_of_month,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [WDAY_W-1:0]  weekday;
        logic [YEAR_W-1:0]  year_offset;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  day_of_month;
    } calendar_t;

    calendar_t dates_q[$];

    function automatic bit gregorian_leap(input int unsigned yoff);
        int unsigned y;
        y = 1970 + yoff;
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // mon counts from 0 for january
    function automatic int unsigned days_in_month(input int unsigned mon,
                                                  input int unsigned yoff);
        case (mon)
            1:          return gregorian_leap(yoff) ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic calendar_t break_down_epoch(input logic [EPOCH_W-1:0] secs);
        calendar_t   c;
        int unsigned t;
        int unsigned days;
        int unsigned yoff;
        int unsigned mon;
        int unsigned ylen;
        t = secs;
        c.second = SEC_W'(t % 60);
        t = t / 60;
        c.minute = MIN_W'(t % 60);
        t = t / 60;
        c.hour = HOUR_W'(t % 24);
        days = t / 24;
        // day zero was a thursday
        c.weekday = WDAY_W'((days + 4) % 7 + 1);
        yoff = 0;
        ylen = gregorian_leap(0) ? 366 : 365;
        while (days >= ylen) begin
            days = days - ylen;
            yoff = yoff + 1;
            ylen = gregorian_leap(yoff) ? 366 : 365;
        end
        mon = 0;
        while (mon < 11 && days >= days_in_month(mon, yoff)) begin
            days = days - days_in_month(mon, yoff);
            mon = mon + 1;
        end
        c.year_offset  = YEAR_W'(yoff);
        c.month        = MONTH_W'(mon + 1);
        c.day_of_month = MDAY_W'(days + 1);
        return c;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        calendar_t want;
        calendar_t got;
        if (!aresetn) begin
            dates_q.delete();
        end else begin
            if (s_valid && s_ready)
                dates_q.push_back(break_down_epoch(s_epoch_seconds));
            if (m_valid && m_ready) begin
                got = '{second: m_second, minute: m_minute, hour: m_hour,
                        weekday: m_weekday, year_offset: m_year_offset,
                        month: m_month, day_of_month: m_day_of_month};
                if (dates_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t checker: result beat with nothing outstanding", $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    want = dates_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display("%0t checker: exp s%0d m%0d h%0d wd%0d y+%0d mo%0d d%0d",
                                     $realtime, want.second, want.minute, want.hour,
                                     want.weekday, want.year_offset, want.month,
                                     want.day_of_month);
                            $display("%0t checker: got s%0d m%0d h%0d wd%0d y+%0d mo%0d d%0d",
                                     $realtime, got.second, got.minute, got.hour,
                                     got.weekday, got.year_offset, got.month,
                                     got.day_of_month);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= dates_q.size();
    end

endmodule

// ----- verif/tb_epoch_seconds_to_calendar_top.sv -----
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_top;
    import etcal_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1930;
    localparam int DRAIN_CYCLES = 300;

    logic                 aclk;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [EPOCH_W-1:0]   s_epoch_seconds = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [SEC_W-1:0]     m_second;
    logic [MIN_W-1:0]     m_minute;
    logic [HOUR_W-1:0]    m_hour;
    logic [WDAY_W-1:0]    m_weekday;
    logic [YEAR_W-1:0]    m_year_offset;
    logic [MONTH_W-1:0]   m_month;
    logic [MDAY_W-1:0]    m_day_of_month;

    int fail_count;
    int pending;
    int src_idle_pct = 7;
    int dst_idle_pct = 62;
    int dates_sent   = 0;
    int quiet_cycles = 0;

    logic [EPOCH_W-1:0] directed_q[$];

    epoch_seconds_to_calendar_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_second        (m_second),
        .m_minute        (m_minute),
        .m_hour          (m_hour),
        .m_weekday       (m_weekday),
        .m_year_offset   (m_year_offset),
        .m_month         (m_month),
        .m_day_of_month  (m_day_of_month)
    );

    cal_breakdown_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_second        (m_second),
        .m_minute        (m_minute),
        .m_hour          (m_hour),
        .m_weekday       (m_weekday),
        .m_year_offset   (m_year_offset),
        .m_month         (m_month),
        .m_day_of_month  (m_day_of_month),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                         $realtime, STALL_LIMIT, pending);
                $display("tb_epoch_seconds_to_calendar_top: done, errors");
                $finish;
            end
        end
    end

    function automatic bit leap_offset(input int yoff);
        int y;
        y = 1970 + yoff;
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // day count from 1970-01-01 to the first of the month, mon from 1
    function automatic longint first_of_month(input int yoff, input int mon);
        longint d;
        int     y;
        int     m;
        d = 0;
        for (y = 0; y < yoff; y++)
            d += leap_offset(y) ? 366 : 365;
        for (m = 1; m < mon; m++) begin
            if (m == 2)
                d += leap_offset(yoff) ? 29 : 28;
            else if (m == 4 || m == 6 || m == 9 || m == 11)
                d += 30;
            else
                d += 31;
        end
        return d;
    endfunction

    function automatic logic [EPOCH_W-1:0] date_to_epoch(input int yoff, input int mon,
                                                         input int mday, input int hh,
                                                         input int mm, input int ss);
        longint t;
        t = (first_of_month(yoff, mon) + mday - 1) * 86400 + hh * 3600 + mm * 60 + ss;
        return EPOCH_W'(t);
    endfunction

    // half the draws land near a month or year edge, the rest anywhere or near the ends
    function automatic logic [EPOCH_W-1:0] pick_epoch();
        longint base;
        int     sel;
        sel = $urandom_range(9);
        if (sel <= 3)
            return $urandom();
        if (sel <= 7) begin
            base = first_of_month($urandom_range(136), $urandom_range(1, 12)) * 86400;
            case ($urandom_range(3))
                0: base = base - 1;
                1: base = base + $urandom_range(59);
                2: base = base - $urandom_range(1, 86400);
                default: base = base + $urandom_range(2 * 86400) - 86400;
            endcase
            return EPOCH_W'(base);
        end
        if (sel == 8) begin
            // around the end of february in years divisible by four
            base = first_of_month($urandom_range(34) * 4 + 2, 3) * 86400;
            return EPOCH_W'(base - $urandom_range(2) * 86400 + $urandom_range(86399));
        end
        if ($urandom_range(1))
            return EPOCH_W'($urandom_range(400000));
        return 32'hFFFF_FFFF - $urandom_range(400000);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_epoch(input logic [EPOCH_W-1:0] secs);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        dates_sent++;
        @(negedge aclk);
    endtask

    initial begin
        int i;
        int phase;

        directed_q = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        directed_q.push_back(date_to_epoch(0, 12, 31, 23, 59, 59));
        directed_q.push_back(date_to_epoch(2, 2, 29, 0, 0, 0));
        directed_q.push_back(date_to_epoch(2, 12, 31, 23, 59, 59));
        directed_q.push_back(date_to_epoch(30, 2, 29, 12, 30, 30));
        directed_q.push_back(date_to_epoch(30, 3, 1, 0, 0, 0));
        directed_q.push_back(date_to_epoch(30, 12, 31, 23, 59, 59));
        directed_q.push_back(date_to_epoch(129, 12, 31, 23, 59, 59));
        directed_q.push_back(date_to_epoch(130, 2, 28, 23, 59, 59));
        directed_q.push_back(date_to_epoch(130, 3, 1, 0, 0, 0));
        directed_q.push_back(date_to_epoch(136, 1, 31, 23, 59, 59));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_q[k])
            send_epoch(directed_q[k]);

        // hold off until the pipeline has emptied completely
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 7;  dst_idle_pct = 62; end
                1: begin src_idle_pct = 62; dst_idle_pct = 7;  end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            for (i = 0; i < RANDOM_ITEMS / 3; i++)
                send_epoch(pick_epoch());
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run: %0d conversions (%0d directed) incl. 32-bit extremes, leap days",
                 dates_sent, directed_q.size());
        $display("run: 2000/2100 century years and month edges, under three stall mixes");
        if (fail_count == 0 && pending == 0)
            $display("tb_epoch_seconds_to_calendar_top: done, clean");
        else
            $display("tb_epoch_seconds_to_calendar_top: done, errors");
        $finish;
    end

endmodule
